// File: hdl/owss_pkg.sv
`default_nettype none

package owss_pkg;

  localparam logic [1:0] CMD_TICK         = 2'd0;
  localparam logic [1:0] CMD_MEASURE      = 2'd1;
  localparam logic [1:0] CMD_STORE_LIMITS = 2'd2;
  localparam logic [1:0] CMD_READ_LIMITS  = 2'd3;

  localparam logic [2:0] CFG_RESET_LOW        = 3'd0;
  localparam logic [2:0] CFG_PRESENCE_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_POST_RESET       = 3'd2;
  localparam logic [2:0] CFG_SLOT             = 3'd3;
  localparam logic [2:0] CFG_BYTE_GAP         = 3'd4;

  localparam logic [11:0] RESET_LOW_DEFAULT        = 12'd480;
  localparam logic [11:0] PRESENCE_TIMEOUT_DEFAULT = 12'd255;
  localparam logic [11:0] POST_RESET_DEFAULT       = 12'd420;
  localparam logic [7:0]  SLOT_DEFAULT             = 8'd60;
  localparam logic [7:0]  BYTE_GAP_DEFAULT         = 8'd10;

  localparam logic [7:0] ROM_SKIP        = 8'hcc;
  localparam logic [7:0] FN_CONVERT      = 8'h44;
  localparam logic [7:0] FN_READ_PAD     = 8'hbe;
  localparam logic [7:0] FN_WRITE_PAD    = 8'h4e;
  localparam logic [7:0] PAD_CONFIG_BYTE = 8'h7f;
  localparam logic [7:0] FN_COPY_PAD     = 8'h48;
  localparam logic [7:0] FN_RECALL       = 8'hb8;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_PRESENCE,
    PH_POST,
    PH_SLOT_START,
    PH_SLOT_BODY,
    PH_GAP
  } phase_t;

  typedef enum logic [2:0] {
    OP_END,
    OP_RESET,
    OP_WRITE,
    OP_WRITE_HI,
    OP_WRITE_LO,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
  } seq_op_t;

  typedef struct packed {
    logic [1:0] command;
    logic       dq_line;
    logic [7:0] high_limit;
    logic [7:0] low_limit;
  } in_beat_t;

  typedef struct packed {
    logic              dq_pull_low;
    logic              busy_res;
    logic              done_res;
    logic              presence_seen;
    logic signed [7:0] temp_whole;
    logic [3:0]        temp_fraction;
    logic [7:0]        high_limit_read;
    logic [7:0]        low_limit_read;
  } out_beat_t;

  typedef struct packed {
    logic [11:0] reset_low_ticks;
    logic [11:0] presence_timeout_ticks;
    logic [11:0] post_reset_ticks;
    logic [7:0]  slot_ticks;
    logic [7:0]  byte_gap_ticks;
  } cfg_t;

  function automatic seq_op_t seq_op(input logic [1:0] cmd, input logic [3:0] step);
    seq_op_t op;
    op = '{kind: OP_END, data: 8'h00};
    case (cmd)
      CMD_MEASURE: begin
        case (step)
          4'd0: op = '{kind: OP_RESET, data: 8'h00};
          4'd1: op = '{kind: OP_WRITE, data: ROM_SKIP};
          4'd2: op = '{kind: OP_WRITE, data: FN_CONVERT};
          4'd3: op = '{kind: OP_RESET, data: 8'h00};
          4'd4: op = '{kind: OP_WRITE, data: ROM_SKIP};
          4'd5: op = '{kind: OP_WRITE, data: FN_READ_PAD};
          4'd6: op = '{kind: OP_READ, data: 8'h00};
          4'd7: op = '{kind: OP_READ, data: 8'h00};
          default: op = '{kind: OP_END, data: 8'h00};
        endcase
      end
      CMD_STORE_LIMITS: begin
        case (step)
          4'd0:  op = '{kind: OP_RESET, data: 8'h00};
          4'd1:  op = '{kind: OP_WRITE, data: ROM_SKIP};
          4'd2:  op = '{kind: OP_WRITE, data: FN_WRITE_PAD};
          4'd3:  op = '{kind: OP_WRITE_HI, data: 8'h00};
          4'd4:  op = '{kind: OP_WRITE_LO, data: 8'h00};
          4'd5:  op = '{kind: OP_WRITE, data: PAD_CONFIG_BYTE};
          4'd6:  op = '{kind: OP_RESET, data: 8'h00};
          4'd7:  op = '{kind: OP_WRITE, data: ROM_SKIP};
          4'd8:  op = '{kind: OP_WRITE, data: FN_COPY_PAD};
          4'd9:  op = '{kind: OP_RESET, data: 8'h00};
          4'd10: op = '{kind: OP_WRITE, data: ROM_SKIP};
          4'd11: op = '{kind: OP_WRITE, data: FN_RECALL};
          default: op = '{kind: OP_END, data: 8'h00};
        endcase
      end
      CMD_READ_LIMITS: begin
        case (step)
          4'd0: op = '{kind: OP_RESET, data: 8'h00};
          4'd1: op = '{kind: OP_WRITE, data: ROM_SKIP};
          4'd2: op = '{kind: OP_WRITE, data: FN_READ_PAD};
          4'd3: op = '{kind: OP_READ, data: 8'h00};
          4'd4: op = '{kind: OP_READ, data: 8'h00};
          4'd5: op = '{kind: OP_READ, data: 8'h00};
          4'd6: op = '{kind: OP_READ, data: 8'h00};
          default: op = '{kind: OP_END, data: 8'h00};
        endcase
      end
      default: op = '{kind: OP_END, data: 8'h00};
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// File: hdl/owss_cfg_regs.sv
`default_nettype none

module owss_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [11:0]   cfg_wr_data,
  output owss_pkg::cfg_t     cfg
);

  owss_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks        <= owss_pkg::RESET_LOW_DEFAULT;
      cfg_r.presence_timeout_ticks <= owss_pkg::PRESENCE_TIMEOUT_DEFAULT;
      cfg_r.post_reset_ticks       <= owss_pkg::POST_RESET_DEFAULT;
      cfg_r.slot_ticks             <= owss_pkg::SLOT_DEFAULT;
      cfg_r.byte_gap_ticks         <= owss_pkg::BYTE_GAP_DEFAULT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        owss_pkg::CFG_RESET_LOW:        cfg_r.reset_low_ticks        <= cfg_wr_data;
        owss_pkg::CFG_PRESENCE_TIMEOUT: cfg_r.presence_timeout_ticks <= cfg_wr_data;
        owss_pkg::CFG_POST_RESET:       cfg_r.post_reset_ticks       <= cfg_wr_data;
        owss_pkg::CFG_SLOT:             cfg_r.slot_ticks             <= cfg_wr_data[7:0];
        owss_pkg::CFG_BYTE_GAP:         cfg_r.byte_gap_ticks         <= cfg_wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hdl/owss_engine.sv
`default_nettype none

module owss_engine #(
  parameter int TICK_COUNT_WIDTH = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step_en,
  input  wire owss_pkg::in_beat_t in_beat,
  input  wire owss_pkg::cfg_t     cfg,
  output owss_pkg::out_beat_t res
);

  localparam int W  = TICK_COUNT_WIDTH;
  localparam int CW = (W > 12) ? W : 12;
  localparam logic [W-1:0] TICK_MAX = {W{1'b1}};

  owss_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]   op_step_r, op_step_nxt;
  logic [1:0]   active_r, active_nxt;
  logic [7:0]   shift_r, shift_nxt;
  logic [2:0]   bit_r, bit_nxt;
  logic [W-1:0] tick_r, tick_nxt;
  logic [2:0]   read_idx_r, read_idx_nxt;
  logic [7:0]   first_r, first_nxt;
  logic [7:0]   held_hi_r, held_hi_nxt;
  logic [7:0]   held_lo_r, held_lo_nxt;
  logic [7:0]   whole_r, whole_nxt;
  logic [3:0]   frac_r, frac_nxt;
  logic [7:0]   hi_read_r, hi_read_nxt;
  logic [7:0]   lo_read_r, lo_read_nxt;
  logic         presence_r, presence_nxt;

  logic            done;
  logic            pull;
  logic            launch;
  logic [3:0]      launch_step;
  logic [W:0]      cnt;
  owss_pkg::seq_op_t cur_op, new_op;

  logic [W-1:0] lim_reset, lim_presence, lim_post, lim_slot, lim_gap;

  function automatic logic [W-1:0] tick_limit(input logic [11:0] v);
    logic [CW-1:0] ext;
    logic [W-1:0]  lim;
    ext = CW'(v);
    if (ext > CW'(TICK_MAX)) lim = TICK_MAX;
    else lim = W'(ext);
    if (lim == '0) lim = W'(1);
    return lim;
  endfunction

  // returns {reached, next count}
  function automatic logic [W:0] count_step(input logic [W-1:0] c, input logic [W-1:0] lim);
    logic [W-1:0] inc;
    inc = (c != TICK_MAX) ? c + W'(1) : c;
    if (inc >= lim) return {1'b1, {W{1'b0}}};
    return {1'b0, inc};
  endfunction

  assign lim_reset    = tick_limit(cfg.reset_low_ticks);
  assign lim_presence = tick_limit(cfg.presence_timeout_ticks);
  assign lim_post     = tick_limit(cfg.post_reset_ticks);
  assign lim_slot     = tick_limit({4'd0, cfg.slot_ticks});
  assign lim_gap      = tick_limit({4'd0, cfg.byte_gap_ticks});

  assign cur_op = owss_pkg::seq_op(active_r, op_step_r);

  always_comb begin
    phase_nxt    = phase_r;
    op_step_nxt  = op_step_r;
    active_nxt   = active_r;
    shift_nxt    = shift_r;
    bit_nxt      = bit_r;
    tick_nxt     = tick_r;
    read_idx_nxt = read_idx_r;
    first_nxt    = first_r;
    held_hi_nxt  = held_hi_r;
    held_lo_nxt  = held_lo_r;
    whole_nxt    = whole_r;
    frac_nxt     = frac_r;
    hi_read_nxt  = hi_read_r;
    lo_read_nxt  = lo_read_r;
    presence_nxt = presence_r;
    done         = 1'b0;
    launch       = 1'b0;
    launch_step  = op_step_r + 4'd1;
    cnt          = '0;
    new_op       = '{kind: owss_pkg::OP_END, data: 8'h00};

    unique case (phase_r)
      owss_pkg::PH_IDLE: begin
        if (in_beat.command != owss_pkg::CMD_TICK) begin
          active_nxt = in_beat.command;
          if (in_beat.command == owss_pkg::CMD_STORE_LIMITS) begin
            held_hi_nxt = in_beat.high_limit;
            held_lo_nxt = in_beat.low_limit;
          end
          read_idx_nxt = 3'd0;
          launch       = 1'b1;
          launch_step  = 4'd0;
        end
      end
      owss_pkg::PH_RST_LOW: begin
        cnt      = count_step(tick_r, lim_reset);
        tick_nxt = cnt[W-1:0];
        if (cnt[W]) phase_nxt = owss_pkg::PH_PRESENCE;
      end
      owss_pkg::PH_PRESENCE: begin
        if (!in_beat.dq_line) begin
          presence_nxt = 1'b1;
          tick_nxt     = '0;
          phase_nxt    = owss_pkg::PH_POST;
        end else begin
          cnt      = count_step(tick_r, lim_presence);
          tick_nxt = cnt[W-1:0];
          if (cnt[W]) begin
            presence_nxt = 1'b0;
            phase_nxt    = owss_pkg::PH_POST;
          end
        end
      end
      owss_pkg::PH_POST: begin
        cnt      = count_step(tick_r, lim_post);
        tick_nxt = cnt[W-1:0];
        if (cnt[W]) launch = 1'b1;
      end
      owss_pkg::PH_SLOT_START: begin
        tick_nxt  = '0;
        phase_nxt = owss_pkg::PH_SLOT_BODY;
      end
      owss_pkg::PH_SLOT_BODY: begin
        if (cur_op.kind == owss_pkg::OP_READ && tick_r == '0) begin
          shift_nxt = {in_beat.dq_line, shift_r[7:1]};
        end
        cnt      = count_step(tick_r, lim_slot);
        tick_nxt = cnt[W-1:0];
        if (cnt[W]) begin
          if (cur_op.kind != owss_pkg::OP_READ) shift_nxt = {1'b0, shift_r[7:1]};
          bit_nxt = bit_r + 3'd1;
          if (bit_nxt == 3'd0) begin
            if (cur_op.kind == owss_pkg::OP_READ) begin
              if (active_r == owss_pkg::CMD_MEASURE) begin
                if (read_idx_r == 3'd0) begin
                  first_nxt = shift_nxt;
                end else if (read_idx_r == 3'd1) begin
                  whole_nxt = {shift_nxt[3:0], first_r[7:4]};
                  frac_nxt  = first_r[3:0];
                end
              end else if (active_r == owss_pkg::CMD_READ_LIMITS) begin
                if (read_idx_r == 3'd2) hi_read_nxt = shift_nxt;
                else if (read_idx_r == 3'd3) lo_read_nxt = shift_nxt;
              end
              read_idx_nxt = read_idx_r + 3'd1;
              launch       = 1'b1;
            end else if (cfg.byte_gap_ticks != 8'd0) begin
              tick_nxt  = '0;
              phase_nxt = owss_pkg::PH_GAP;
            end else begin
              launch = 1'b1;
            end
          end else begin
            phase_nxt = owss_pkg::PH_SLOT_START;
          end
        end
      end
      owss_pkg::PH_GAP: begin
        cnt      = count_step(tick_r, lim_gap);
        tick_nxt = cnt[W-1:0];
        if (cnt[W]) launch = 1'b1;
      end
      default: phase_nxt = owss_pkg::PH_IDLE;
    endcase

    if (launch) begin
      new_op      = owss_pkg::seq_op(active_nxt, launch_step);
      op_step_nxt = launch_step;
      tick_nxt    = '0;
      bit_nxt     = 3'd0;
      case (new_op.kind)
        owss_pkg::OP_RESET: phase_nxt = owss_pkg::PH_RST_LOW;
        owss_pkg::OP_WRITE: begin
          shift_nxt = new_op.data;
          phase_nxt = owss_pkg::PH_SLOT_START;
        end
        owss_pkg::OP_WRITE_HI: begin
          shift_nxt = held_hi_nxt;
          phase_nxt = owss_pkg::PH_SLOT_START;
        end
        owss_pkg::OP_WRITE_LO: begin
          shift_nxt = held_lo_nxt;
          phase_nxt = owss_pkg::PH_SLOT_START;
        end
        owss_pkg::OP_READ: begin
          shift_nxt = 8'h00;
          phase_nxt = owss_pkg::PH_SLOT_START;
        end
        default: begin
          phase_nxt   = owss_pkg::PH_IDLE;
          op_step_nxt = 4'd0;
          done        = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    unique case (phase_r)
      owss_pkg::PH_RST_LOW:    pull = 1'b1;
      owss_pkg::PH_SLOT_START: pull = 1'b1;
      owss_pkg::PH_SLOT_BODY:  pull = (cur_op.kind != owss_pkg::OP_READ) && !shift_r[0];
      default:                 pull = 1'b0;
    endcase
  end

  always_comb begin
    res.dq_pull_low     = pull;
    res.busy_res        = (phase_nxt != owss_pkg::PH_IDLE);
    res.done_res        = done;
    res.presence_seen   = presence_nxt;
    res.temp_whole      = whole_nxt;
    res.temp_fraction   = frac_nxt;
    res.high_limit_read = hi_read_nxt;
    res.low_limit_read  = lo_read_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= owss_pkg::PH_IDLE;
      op_step_r  <= '0;
      active_r   <= '0;
      shift_r    <= '0;
      bit_r      <= '0;
      tick_r     <= '0;
      read_idx_r <= '0;
      first_r    <= '0;
      held_hi_r  <= '0;
      held_lo_r  <= '0;
      whole_r    <= '0;
      frac_r     <= '0;
      hi_read_r  <= '0;
      lo_read_r  <= '0;
      presence_r <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      op_step_r  <= op_step_nxt;
      active_r   <= active_nxt;
      shift_r    <= shift_nxt;
      bit_r      <= bit_nxt;
      tick_r     <= tick_nxt;
      read_idx_r <= read_idx_nxt;
      first_r    <= first_nxt;
      held_hi_r  <= held_hi_nxt;
      held_lo_r  <= held_lo_nxt;
      whole_r    <= whole_nxt;
      frac_r     <= frac_nxt;
      hi_read_r  <= hi_read_nxt;
      lo_read_r  <= lo_read_nxt;
      presence_r <= presence_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/owss_out_stage.sv
`default_nettype none

module owss_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire owss_pkg::out_beat_t res,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output owss_pkg::out_beat_t out_beat
);

  logic                out_valid_r, out_valid_nxt;
  owss_pkg::out_beat_t beat_r;

  assign in_stall = out_valid_r && out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) beat_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = beat_r;

endmodule

`default_nettype wire

// File: hdl/one_wire_sensor_sequencer.sv
// one-wire bus master that runs temperature sensor sequences
//
// in channel (in_valid / in_stall / in_beat): one beat is one bus tick and
// carries a command, the sampled dq line and the two limit bytes. a nonzero
// command starts measure, store limits or read limits when the bus is idle;
// it is ignored while busy.
// out channel (out_valid / out_stall / out_beat): exactly one beat per input
// beat, in order, with the line drive, busy/done flags, presence and the
// last measured and read values.
// cfg port (cfg_wr_en / cfg_index / cfg_wr_data): tick counts for reset low,
// presence timeout, post reset wait, bit slot and byte gap; write only while
// idle.
// an accepted in beat's out beat is registered and shows in the next cycle;
// one beat is taken every cycle unless in_stall is raised, set by the single
// state update per tick and the output register. while out_stall holds a
// waiting beat, in_stall is raised and the bus state holds. reset returns the
// bus to idle with the line released and the tick registers at their defaults.
`default_nettype none

module one_wire_sensor_sequencer #(
  parameter int TICK_COUNT_WIDTH = 12
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire owss_pkg::in_beat_t in_beat,
  output logic                out_valid,
  input  wire logic           out_stall,
  output owss_pkg::out_beat_t out_beat,
  input  wire logic           cfg_wr_en,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [11:0]    cfg_wr_data
);

  owss_pkg::cfg_t      cfg;
  owss_pkg::out_beat_t res;
  logic                in_fire;

  assign in_fire = in_valid && !in_stall;

  owss_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  owss_engine #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .in_beat (in_beat),
    .cfg     (cfg),
    .res     (res)
  );

  owss_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .res       (res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_beat.done_res && out_beat.busy_res))
    else $error("done and busy both set");

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no waiting beat");

  a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("accepted beat produced no result");

  a_pull_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.dq_pull_low) |-> (out_beat.busy_res || out_beat.done_res))
    else $error("line driven while idle");

endmodule

`default_nettype wire
